// ===== hdl/bprl_pkg.sv =====
package bprl_pkg;

    // power range that every commanded power is saturated to
    localparam int POWER_WIDTH = 32;

    // working width of the ramp bounds, wide enough for prev +/- delta
    localparam int SUM_W = (POWER_WIDTH + 1 > 40) ? POWER_WIDTH + 1 : 40;

    localparam logic signed [SUM_W-1:0] PWR_MAX =
        SUM_W'((longint'(1) <<< (POWER_WIDTH - 1)) - longint'(1));
    localparam logic signed [SUM_W-1:0] PWR_MIN = -PWR_MAX - SUM_W'(1);

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CHARGE_POWER    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DISCHARGE_POWER = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_CHARGE_LEVEL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CHARGE_LEVEL    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RAMP_RATE       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_TEMPERATURE     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TEMPERATURE     = 3'd6;

    // reason codes
    localparam logic [3:0] RSN_WITHIN       = 4'd0;
    localparam logic [3:0] RSN_TEMP         = 4'd1;
    localparam logic [3:0] RSN_FULL         = 4'd2;
    localparam logic [3:0] RSN_EMPTY        = 4'd3;
    localparam logic [3:0] RSN_CHARGEMAX    = 4'd4;
    localparam logic [3:0] RSN_DISCHARGEMAX = 4'd5;
    localparam logic [3:0] RSN_RAMPBLOCKED  = 4'd6;
    localparam logic [3:0] RSN_RAMPDOWN     = 4'd7;
    localparam logic [3:0] RSN_RAMPUP       = 4'd8;
    localparam logic [3:0] RSN_NEGDT        = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LIMITED = 2'd1;
    localparam logic [1:0] ST_NEGDT   = 2'd2;

    // mode codes
    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_DISCHARGE = 2'd1;
    localparam logic [1:0] MODE_CHARGE    = 2'd2;

    // reciprocals of 125 for x / 1000 = (x >> 3) / 125
    localparam int DIV1_K = 35;
    localparam int DIV2_K = 37;
    localparam logic [28:0] DIV1_M = 29'(((64'd1 << DIV1_K) + 64'd124) / 64'd125);
    localparam logic [30:0] DIV2_M = 31'(((64'd1 << DIV2_K) + 64'd124) / 64'd125);
    localparam logic [9:0]  MS_PER_S = 10'd1000;

    typedef struct packed {
        logic        [30:0] max_charge_power;
        logic        [30:0] max_discharge_power;
        logic        [13:0] min_charge_level;
        logic        [13:0] max_charge_level;
        logic        [30:0] max_ramp_rate;
        logic signed [14:0] min_temperature;
        logic signed [14:0] max_temperature;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] pow;
        logic        [3:0]  reason;
        logic        [1:0]  status;
    } cons_t;

    typedef struct packed {
        cons_t              cons;
        logic               has_prev;
        logic               neg_dt;
        logic               ramp_zero;
        logic signed [31:0] prev;
    } item_t;

    function automatic logic signed [SUM_W-1:0] sat_power(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > PWR_MAX) begin
            r = PWR_MAX;
        end else if (v < PWR_MIN) begin
            r = PWR_MIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/bprl_constraint.sv =====
module bprl_constraint (
    input  bprl_pkg::cfg_t      cfg,
    input  logic [13:0]         charge_level,
    input  logic signed [14:0]  temperature,
    input  logic signed [31:0]  target_power,
    output bprl_pkg::cons_t     cons
);

    logic signed [33:0] req_x;
    logic signed [33:0] chg_lim;
    logic signed [33:0] dis_lim;
    logic               req_neg;
    logic               req_pos;

    assign req_x   = 34'(target_power);
    assign chg_lim = -$signed({3'b000, cfg.max_charge_power});
    assign dis_lim = $signed({3'b000, cfg.max_discharge_power});
    assign req_neg = target_power[31];
    assign req_pos = !target_power[31] && (target_power != 32'sd0);

    // checks in priority order
    always_comb begin
        cons.status = bprl_pkg::ST_LIMITED;
        if (temperature < cfg.min_temperature || temperature > cfg.max_temperature) begin
            cons.pow    = 32'sd0;
            cons.reason = bprl_pkg::RSN_TEMP;
        end else if (req_neg && charge_level >= cfg.max_charge_level) begin
            cons.pow    = 32'sd0;
            cons.reason = bprl_pkg::RSN_FULL;
        end else if (req_pos && charge_level <= cfg.min_charge_level) begin
            cons.pow    = 32'sd0;
            cons.reason = bprl_pkg::RSN_EMPTY;
        end else if (req_x < chg_lim) begin
            cons.pow    = $signed(chg_lim[31:0]);
            cons.reason = bprl_pkg::RSN_CHARGEMAX;
        end else if (req_x > dis_lim) begin
            cons.pow    = $signed(dis_lim[31:0]);
            cons.reason = bprl_pkg::RSN_DISCHARGEMAX;
        end else begin
            cons.pow    = target_power;
            cons.reason = bprl_pkg::RSN_WITHIN;
            cons.status = bprl_pkg::ST_OK;
        end
    end

endmodule

// ===== hdl/battery_power_constraint_ramp_limiter_top.sv =====
// Battery power setpoint limiter. Each item carries a requested power
// (watts, discharge positive, charge negative) with the measured charge
// level and temperature, and optionally the previous commanded power and
// the elapsed time. The item is first clamped by the temperature window,
// the charge level window and the charge/discharge power limits, then,
// when prev_valid is set, slew limited to max_ramp_rate * elapsed_ms /
// 1000 watts around the previous power (allowed change rounded down).
// A negative elapsed time with prev_valid set gives power 0 with the
// negative-time status. The block keeps no state between items: it takes
// one item per clock unless a stall on the result side holds it. There
// are seven register stages, the first loaded at the accepting edge and
// the last the output register; their number is set by the slew bound
// path: the split rate * ms product, two divides by 1000 done as a shift
// and a multiply by a reciprocal of 125 with the remainder folded in
// between, the allowed-change add, the bound add and the final compare.
// A stall on the result side holds the pipeline, and empty stages still
// take items while a result waits.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
// and must only change while no item is in flight.
module battery_power_constraint_ramp_limiter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bprl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bprl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // request items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // charge_level[13:0], temperature[28:14], target_power[60:29],
    // previous_power[92:61], elapsed_ms[109:93], zero pad[111:110]
    input  logic [111:0]                      s_axis_tdata,
    // prev_valid[0]
    input  logic [0:0]                        s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // power[31:0], mode[33:32], status[35:34], reason[39:36]
    output logic [39:0]                       m_axis_tdata
);

    localparam int SW = bprl_pkg::SUM_W;

    // configuration registers
    bprl_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_charge_power    <= 31'd0;
            cfg_reg.max_discharge_power <= 31'd0;
            cfg_reg.min_charge_level    <= 14'd1000;
            cfg_reg.max_charge_level    <= 14'd9000;
            cfg_reg.max_ramp_rate       <= 31'd0;
            cfg_reg.min_temperature     <= -15'sd2000;
            cfg_reg.max_temperature     <= 15'sd5000;
        end else if (cfg_we) begin
            case (cfg_addr)
                bprl_pkg::REG_MAX_CHARGE_POWER:    cfg_reg.max_charge_power    <= cfg_wdata;
                bprl_pkg::REG_MAX_DISCHARGE_POWER: cfg_reg.max_discharge_power <= cfg_wdata;
                bprl_pkg::REG_MIN_CHARGE_LEVEL:    cfg_reg.min_charge_level    <= cfg_wdata[13:0];
                bprl_pkg::REG_MAX_CHARGE_LEVEL:    cfg_reg.max_charge_level    <= cfg_wdata[13:0];
                bprl_pkg::REG_MAX_RAMP_RATE:       cfg_reg.max_ramp_rate       <= cfg_wdata;
                bprl_pkg::REG_MIN_TEMPERATURE: begin
                    cfg_reg.min_temperature <= $signed(cfg_wdata[14:0]);
                end
                bprl_pkg::REG_MAX_TEMPERATURE: begin
                    cfg_reg.max_temperature <= $signed(cfg_wdata[14:0]);
                end
                default: ;
            endcase
        end
    end

    // unpack the request item
    logic        [13:0] in_level;
    logic signed [14:0] in_temp;
    logic signed [31:0] in_req;
    logic signed [31:0] in_prev;
    logic signed [16:0] in_ms;
    logic               in_has_prev;

    assign in_level    = s_axis_tdata[13:0];
    assign in_temp     = $signed(s_axis_tdata[28:14]);
    assign in_req      = $signed(s_axis_tdata[60:29]);
    assign in_prev     = $signed(s_axis_tdata[92:61]);
    assign in_ms       = $signed(s_axis_tdata[109:93]);
    assign in_has_prev = s_axis_tuser[0];

    // per-stage advance: a stage moves when it is empty or the next one moves
    logic [7:1] vld_reg;
    logic [8:1] adv;

    always_comb begin
        adv[8] = m_axis_tready;
        for (int i = 7; i >= 1; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[1];
    assign m_axis_tvalid = vld_reg[7];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int i = 2; i <= 7; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: constraint clamp and the two partial products of rate * ms
    bprl_pkg::cons_t cons_next;

    bprl_constraint u_constraint (
        .cfg          (cfg_reg),
        .charge_level (in_level),
        .temperature  (in_temp),
        .target_power (in_req),
        .cons         (cons_next)
    );

    logic [15:0]     ms_pos;
    logic [30:0]     prod_hi_next;
    logic [31:0]     prod_lo_next;
    bprl_pkg::item_t item_next;

    // rate split at bit 16 so each product stays narrow
    assign ms_pos       = in_ms[16] ? 16'd0 : in_ms[15:0];
    assign prod_hi_next = 31'(cfg_reg.max_ramp_rate[30:16]) * 31'(ms_pos);
    assign prod_lo_next = 32'(cfg_reg.max_ramp_rate[15:0]) * 32'(ms_pos);

    always_comb begin
        item_next.cons      = cons_next;
        item_next.has_prev  = in_has_prev;
        item_next.neg_dt    = in_has_prev && in_ms[16];
        item_next.ramp_zero = (cfg_reg.max_ramp_rate == 31'd0) || (in_ms == 17'sd0);
        item_next.prev      = in_prev;
    end

    bprl_pkg::item_t s1_item_reg;
    logic [30:0]     s1_hi_reg;
    logic [31:0]     s1_lo_reg;

    always_ff @(posedge aclk) begin
        if (adv[1] && s_axis_tvalid) begin
            s1_item_reg <= item_next;
            s1_hi_reg   <= prod_hi_next;
            s1_lo_reg   <= prod_lo_next;
        end
    end

    // stage 2: high product divided by 1000, reciprocal multiply
    bprl_pkg::item_t s2_item_reg;
    logic [30:0]     s2_hi_reg;
    logic [31:0]     s2_lo_reg;
    logic [56:0]     s2_q1_reg;
    logic [56:0]     q1_next;

    assign q1_next = 57'(s1_hi_reg[30:3]) * 57'(bprl_pkg::DIV1_M);

    always_ff @(posedge aclk) begin
        if (adv[2] && vld_reg[1]) begin
            s2_item_reg <= s1_item_reg;
            s2_hi_reg   <= s1_hi_reg;
            s2_lo_reg   <= s1_lo_reg;
            s2_q1_reg   <= q1_next;
        end
    end

    // stage 3: remainder of the high part folded into the low part
    logic [21:0] qa;
    logic [30:0] ra_full;
    logic [32:0] rsum_next;

    assign qa        = s2_q1_reg[56:35];
    assign ra_full   = s2_hi_reg - 31'(qa * 32'(bprl_pkg::MS_PER_S));
    assign rsum_next = 33'({ra_full[9:0], 16'd0}) + 33'(s2_lo_reg);

    bprl_pkg::item_t s3_item_reg;
    logic [21:0]     s3_qa_reg;
    logic [32:0]     s3_rsum_reg;

    always_ff @(posedge aclk) begin
        if (adv[3] && vld_reg[2]) begin
            s3_item_reg <= s2_item_reg;
            s3_qa_reg   <= qa;
            s3_rsum_reg <= rsum_next;
        end
    end

    // stage 4: low part divided by 1000
    logic [60:0] q2_next;

    assign q2_next = 61'(s3_rsum_reg[32:3]) * 61'(bprl_pkg::DIV2_M);

    bprl_pkg::item_t s4_item_reg;
    logic [21:0]     s4_qa_reg;
    logic [60:0]     s4_q2_reg;

    always_ff @(posedge aclk) begin
        if (adv[4] && vld_reg[3]) begin
            s4_item_reg <= s3_item_reg;
            s4_qa_reg   <= s3_qa_reg;
            s4_q2_reg   <= q2_next;
        end
    end

    // stage 5: allowed change in watts
    logic [37:0] delta_next;

    assign delta_next = 38'({s4_qa_reg, 16'd0}) + 38'(s4_q2_reg[60:37]);

    bprl_pkg::item_t s5_item_reg;
    logic [37:0]     s5_delta_reg;

    always_ff @(posedge aclk) begin
        if (adv[5] && vld_reg[4]) begin
            s5_item_reg  <= s4_item_reg;
            s5_delta_reg <= delta_next;
        end
    end

    // stage 6: ramp bounds around the previous power, not yet saturated
    logic signed [SW-1:0] lo_next;
    logic signed [SW-1:0] hi_next;

    assign lo_next = SW'(s5_item_reg.prev) - SW'(s5_delta_reg);
    assign hi_next = SW'(s5_item_reg.prev) + SW'(s5_delta_reg);

    bprl_pkg::item_t      s6_item_reg;
    logic signed [SW-1:0] s6_lo_reg;
    logic signed [SW-1:0] s6_hi_reg;

    always_ff @(posedge aclk) begin
        if (adv[6] && vld_reg[5]) begin
            s6_item_reg <= s5_item_reg;
            s6_lo_reg   <= lo_next;
            s6_hi_reg   <= hi_next;
        end
    end

    // stage 7: ramp compare, combine with the constraint result
    logic signed [SW-1:0] cpow_x;
    logic signed [SW-1:0] prev_x;
    logic signed [SW-1:0] fpow;
    logic signed [SW-1:0] fpow_sat;
    logic signed [SW-1:0] rpow;
    logic [3:0]           rreason;
    logic [1:0]           rstatus;
    logic [3:0]           freason;
    logic [1:0]           fstatus;
    logic [1:0]           fmode;

    assign cpow_x = SW'(s6_item_reg.cons.pow);
    assign prev_x = SW'(s6_item_reg.prev);

    always_comb begin
        // slew limit
        if (s6_item_reg.ramp_zero) begin
            if (s6_item_reg.cons.pow == s6_item_reg.prev) begin
                rpow    = cpow_x;
                rreason = bprl_pkg::RSN_WITHIN;
                rstatus = bprl_pkg::ST_OK;
            end else begin
                // zero rate or zero time holds the previous power
                rpow    = prev_x;
                rreason = bprl_pkg::RSN_RAMPBLOCKED;
                rstatus = bprl_pkg::ST_LIMITED;
            end
        end else if (cpow_x < s6_lo_reg) begin
            rpow    = s6_lo_reg;
            rreason = bprl_pkg::RSN_RAMPDOWN;
            rstatus = bprl_pkg::ST_LIMITED;
        end else if (cpow_x > s6_hi_reg) begin
            rpow    = s6_hi_reg;
            rreason = bprl_pkg::RSN_RAMPUP;
            rstatus = bprl_pkg::ST_LIMITED;
        end else begin
            rpow    = cpow_x;
            rreason = bprl_pkg::RSN_WITHIN;
            rstatus = bprl_pkg::ST_OK;
        end

        // combine: a limiting constraint keeps its reason
        if (!s6_item_reg.has_prev) begin
            fpow    = cpow_x;
            freason = s6_item_reg.cons.reason;
            fstatus = s6_item_reg.cons.status;
        end else if (s6_item_reg.neg_dt) begin
            fpow    = '0;
            freason = bprl_pkg::RSN_NEGDT;
            fstatus = bprl_pkg::ST_NEGDT;
        end else if (s6_item_reg.cons.status == bprl_pkg::ST_LIMITED) begin
            fpow    = rpow;
            freason = s6_item_reg.cons.reason;
            fstatus = bprl_pkg::ST_LIMITED;
        end else begin
            fpow    = rpow;
            freason = rreason;
            fstatus = rstatus;
        end

        // mode from the sign bit and a zero test of the saturated power
        fpow_sat = bprl_pkg::sat_power(fpow);
        if (fpow_sat[SW-1]) begin
            fmode = bprl_pkg::MODE_CHARGE;
        end else if (fpow_sat != '0) begin
            fmode = bprl_pkg::MODE_DISCHARGE;
        end else begin
            fmode = bprl_pkg::MODE_IDLE;
        end
    end

    // output register
    logic [31:0] out_power_reg;
    logic [1:0]  out_mode_reg;
    logic [1:0]  out_status_reg;
    logic [3:0]  out_reason_reg;

    always_ff @(posedge aclk) begin
        if (adv[7] && vld_reg[6]) begin
            out_power_reg  <= fpow_sat[31:0];
            out_mode_reg   <= fmode;
            out_status_reg <= fstatus;
            out_reason_reg <= freason;
        end
    end

    assign m_axis_tdata = {out_reason_reg, out_status_reg, out_mode_reg, out_power_reg};

`ifndef NO_ASSERTIONS
    // negative elapsed time always comes out as a zeroed result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_status_reg == bprl_pkg::ST_NEGDT) |->
        (out_reason_reg == bprl_pkg::RSN_NEGDT && out_power_reg == 32'd0
         && out_mode_reg == bprl_pkg::MODE_IDLE))
        else $error("negative elapsed time result not zeroed");

    // mode follows the sign of the delivered power
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
        ((out_mode_reg == bprl_pkg::MODE_IDLE) == (out_power_reg == 32'd0)
         && (out_mode_reg == bprl_pkg::MODE_CHARGE) == out_power_reg[31]))
        else $error("mode does not match power sign");

    // an ok result never carries a limiting reason
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_status_reg == bprl_pkg::ST_OK) |->
        (out_reason_reg == bprl_pkg::RSN_WITHIN))
        else $error("ok status with a limiting reason");

    // with no result waiting, the pipeline must take a new item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");
`endif

endmodule
